/* rtl/core/htfd_pkg.sv */
package htfd_pkg;

    localparam int unsigned VALUE_W = 12;
    localparam int unsigned CHAR_W  = 6;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned OUT_DATA_W  = 64;

    localparam logic [INDEX_W-1:0] POS_CHECKSUM = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_HUM_FLOOR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUM_CEILING = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARM_CEILING = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLD_CEILING = 2'd3;

    localparam logic [VALUE_W-1:0] HUM_FLOOR_RESET    = 12'd200;
    localparam logic [VALUE_W-1:0] HUM_CEILING_RESET  = 12'd950;
    localparam logic [VALUE_W-1:0] WARM_CEILING_RESET = 12'd600;
    localparam logic [VALUE_W-1:0] COLD_CEILING_RESET = 12'd200;

    localparam logic [BYTE_W-1:0] SIGN_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LOW_MASK  = 8'h7F;
    localparam logic [3:0] DEC_BASE = 4'd10;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    localparam logic [12:0] DIV10_MUL  = 13'd6554;
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam logic [3:0]  DIV10_SMALL_MUL = 4'd13;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] hum;
        logic [VALUE_W-1:0] tmp;
        logic               neg;
    } frame_result_t;

    function automatic logic [8:0] div10(input logic [VALUE_W-1:0] v);
        logic [24:0] p;
        p = 25'(v) * 25'(DIV10_MUL);
        return p[24:16];
    endfunction

    function automatic logic [5:0] div100(input logic [VALUE_W-1:0] v);
        logic [24:0] p;
        p = 25'(v) * 25'(DIV100_MUL);
        return p[24:19];
    endfunction

    function automatic logic [3:0] hundreds_digit(input logic [5:0] q2);
        logic [9:0] p;
        logic [5:0] t;
        p = 10'(q2) * 10'(DIV10_SMALL_MUL);
        t = 6'(p[9:7]) * 6'(DEC_BASE);
        return 4'(q2 - t);
    endfunction

    function automatic logic [3:0] tens_digit(input logic [8:0] q1, input logic [5:0] q2);
        logic [8:0] t;
        t = 9'(q2) * 9'(DEC_BASE);
        return 4'(q1 - t);
    endfunction

    function automatic logic [3:0] ones_digit(input logic [VALUE_W-1:0] v,
                                              input logic [8:0] q1);
        logic [VALUE_W-1:0] t;
        t = 12'(q1) * 12'(DEC_BASE);
        return 4'(v - t);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        return ASCII_ZERO + 6'(d);
    endfunction

endpackage

/* rtl/core/humidity_temp_frame_decoder_top.sv */
// Channel   Direction  Contents
// s_axis    in         tuser: register_index; tdata: data_byte
// m_axis    out        tuser: frame_ok; tdata: values, sign and ASCII digits
// cfg       in         cfg_index selects a limit register, cfg_data is its new value
//
// While s_axis_tready is high, one item is accepted per cycle through a four-register
// pipeline (input, decode, divide, digits); m_axis_tvalid rises once the checksum item
// has passed the decode, divide and digits registers. Each stage moves on when the
// stage after it is empty or moving, so a stall on m_axis fills the pipeline before
// s_axis_tready falls. Reset clears the valid flags, the stored frame bytes, the held
// values and sets the limit registers to their defaults.
module humidity_temp_frame_decoder_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [htfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [htfd_pkg::VALUE_W-1:0]         cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Bits 7:0 data_byte.
    input  logic [7:0]                           s_axis_tdata,
    // Bits 2:0 register_index.
    input  logic [htfd_pkg::INDEX_W-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // From bit 0: humidity_tenths, temperature_tenths, temperature_negative,
    // hum_hundreds_char, hum_tens_char, hum_ones_char, temp_hundreds_char,
    // temp_tens_char, temp_ones_char, then three zero bits.
    output logic [htfd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // Bit 0 frame_ok.
    output logic [0:0]                           m_axis_tuser
);

    logic                         s1_valid_reg;
    logic [htfd_pkg::INDEX_W-1:0] s1_index_reg;
    logic [htfd_pkg::BYTE_W-1:0]  s1_byte_reg;

    logic                    s2_valid_reg;
    htfd_pkg::frame_result_t s2_res_reg;

    logic                    s3_valid_reg;
    htfd_pkg::frame_result_t s3_res_reg;
    logic [8:0]              s3_hq1_reg;
    logic [5:0]              s3_hq2_reg;
    logic [8:0]              s3_tq1_reg;
    logic [5:0]              s3_tq2_reg;

    logic                              out_valid_reg;
    logic [htfd_pkg::OUT_DATA_W-1:0]   out_data_reg;
    logic                              out_ok_reg;
    logic [htfd_pkg::OUT_DATA_W-1:0]   out_data_next;

    logic out_ready;
    logic s3_ready;
    logic s2_ready;
    logic s1_fire;
    logic has_result;
    htfd_pkg::frame_result_t dec_result;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s3_ready      = !s3_valid_reg || out_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s_axis_tready = !s1_valid_reg || s2_ready;
    assign s1_fire       = s1_valid_reg && s2_ready;
    assign cfg_ready     = 1'b1;

    htfd_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fire       (s1_fire),
        .index      (s1_index_reg),
        .data_byte  (s1_byte_reg),
        .has_result (has_result),
        .result     (dec_result)
    );

    always_comb
    begin
        out_data_next = '0;
        out_data_next[11:0]  = s3_res_reg.hum;
        out_data_next[23:12] = s3_res_reg.tmp;
        out_data_next[24]    = s3_res_reg.neg;
        out_data_next[30:25] = htfd_pkg::digit_char(htfd_pkg::hundreds_digit(s3_hq2_reg));
        out_data_next[36:31] = htfd_pkg::digit_char(htfd_pkg::tens_digit(s3_hq1_reg,
                                                                          s3_hq2_reg));
        out_data_next[42:37] = htfd_pkg::digit_char(htfd_pkg::ones_digit(s3_res_reg.hum,
                                                                          s3_hq1_reg));
        out_data_next[48:43] = htfd_pkg::digit_char(htfd_pkg::hundreds_digit(s3_tq2_reg));
        out_data_next[54:49] = htfd_pkg::digit_char(htfd_pkg::tens_digit(s3_tq1_reg,
                                                                          s3_tq2_reg));
        out_data_next[60:55] = htfd_pkg::digit_char(htfd_pkg::ones_digit(s3_res_reg.tmp,
                                                                          s3_tq1_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_fire && has_result;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            s1_index_reg <= s_axis_tuser;
            s1_byte_reg  <= s_axis_tdata;
        end
        if (s2_ready)
        begin
            s2_res_reg <= dec_result;
        end
        if (s3_ready)
        begin
            s3_res_reg <= s2_res_reg;
            s3_hq1_reg <= htfd_pkg::div10(s2_res_reg.hum);
            s3_hq2_reg <= htfd_pkg::div100(s2_res_reg.hum);
            s3_tq1_reg <= htfd_pkg::div10(s2_res_reg.tmp);
            s3_tq2_reg <= htfd_pkg::div100(s2_res_reg.tmp);
        end
        if (out_ready)
        begin
            out_data_reg <= out_data_next;
            out_ok_reg   <= s3_res_reg.ok;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_ok_reg;

endmodule

/* rtl/core/htfd_decode.sv */
module htfd_decode
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [htfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [htfd_pkg::VALUE_W-1:0]         cfg_data,
    input  logic                                 fire,
    input  logic [htfd_pkg::INDEX_W-1:0]         index,
    input  logic [htfd_pkg::BYTE_W-1:0]          data_byte,
    output logic                                 has_result,
    output htfd_pkg::frame_result_t              result
);

    logic [htfd_pkg::VALUE_W-1:0] hum_floor_reg;
    logic [htfd_pkg::VALUE_W-1:0] hum_ceiling_reg;
    logic [htfd_pkg::VALUE_W-1:0] warm_ceiling_reg;
    logic [htfd_pkg::VALUE_W-1:0] cold_ceiling_reg;
    logic [htfd_pkg::BYTE_W-1:0]  frame_reg [4];
    logic [htfd_pkg::VALUE_W-1:0] held_hum_reg;
    logic [htfd_pkg::VALUE_W-1:0] held_tmp_reg;
    logic                         held_neg_reg;

    logic [htfd_pkg::BYTE_W-1:0]  checksum;
    logic [htfd_pkg::VALUE_W-1:0] hum_raw;
    logic [htfd_pkg::VALUE_W-1:0] hum_capped;
    logic [htfd_pkg::VALUE_W-1:0] hum_next;
    logic [htfd_pkg::VALUE_W-1:0] tmp_raw;
    logic [htfd_pkg::VALUE_W-1:0] tmp_next;
    logic                         neg_next;
    logic                         match;

    always_comb
    begin
        checksum = frame_reg[0] + frame_reg[1] + frame_reg[2] + frame_reg[3];
        match    = (checksum == data_byte);
        hum_raw  = 12'(frame_reg[0]) * 12'(htfd_pkg::DEC_BASE) + 12'(frame_reg[1]);
        tmp_raw  = 12'(frame_reg[2]) * 12'(htfd_pkg::DEC_BASE)
                   + 12'(frame_reg[3] & htfd_pkg::LOW_MASK);
        neg_next = (frame_reg[3] & htfd_pkg::SIGN_MASK) != '0;
        hum_capped = (hum_raw > hum_ceiling_reg) ? hum_ceiling_reg : hum_raw;
        hum_next   = (hum_capped < hum_floor_reg) ? hum_floor_reg : hum_capped;
        if (neg_next)
        begin
            tmp_next = (tmp_raw > cold_ceiling_reg) ? cold_ceiling_reg : tmp_raw;
        end
        else
        begin
            tmp_next = (tmp_raw > warm_ceiling_reg) ? warm_ceiling_reg : tmp_raw;
        end
        has_result = (index == htfd_pkg::POS_CHECKSUM);
        result.ok  = match;
        result.hum = match ? hum_next : held_hum_reg;
        result.tmp = match ? tmp_next : held_tmp_reg;
        result.neg = match ? neg_next : held_neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hum_floor_reg    <= htfd_pkg::HUM_FLOOR_RESET;
            hum_ceiling_reg  <= htfd_pkg::HUM_CEILING_RESET;
            warm_ceiling_reg <= htfd_pkg::WARM_CEILING_RESET;
            cold_ceiling_reg <= htfd_pkg::COLD_CEILING_RESET;
            for (int i = 0; i < 4; i++)
            begin
                frame_reg[i] <= '0;
            end
            held_hum_reg <= '0;
            held_tmp_reg <= '0;
            held_neg_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    htfd_pkg::CFG_HUM_FLOOR:    hum_floor_reg    <= cfg_data;
                    htfd_pkg::CFG_HUM_CEILING:  hum_ceiling_reg  <= cfg_data;
                    htfd_pkg::CFG_WARM_CEILING: warm_ceiling_reg <= cfg_data;
                    htfd_pkg::CFG_COLD_CEILING: cold_ceiling_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (fire)
            begin
                if (!index[2])
                begin
                    frame_reg[index[1:0]] <= data_byte;
                end
                else if (has_result && match)
                begin
                    held_hum_reg <= hum_next;
                    held_tmp_reg <= tmp_next;
                    held_neg_reg <= neg_next;
                end
            end
        end
    end

endmodule
